FILE: sv/dctd_pkg.sv
// Shared constants, register codes and inter-module types for the direct DCT block.
package dctd_pkg;

	// Largest transform block and the cosine table that covers four quarter periods.
	localparam int MAX_LEN     = 64;
	localparam int TABLE_DEPTH = 4 * MAX_LEN;
	localparam int SMP_AW      = $clog2(MAX_LEN);
	localparam int TAB_AW      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(MAX_LEN + 1);
	localparam int IDX_SUM_W   = TAB_AW + 1;

	// Field widths.
	localparam int LEN_W   = 7;
	localparam int SMP_W   = 16;
	localparam int COS_W   = 16;
	localparam int NORM_W  = 15;
	localparam int TIDX_W  = 8;
	localparam int COEF_W  = 32;

	// Datapath widths: factor times sample, times cosine, summed over a block.
	localparam int PA_W        = NORM_W + 1 + SMP_W;
	localparam int PB_W        = PA_W + COS_W;
	localparam int ACC_W       = PB_W + SMP_AW;
	localparam int ROUND_SHIFT = 30;

	// Configuration channel.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_LENGTH = 4'd0,
		REG_INVERSE_MODE = 4'd1,
		REG_NORM_DC      = 4'd2,
		REG_NORM_AC      = 4'd3
	} cfg_reg_t;

	localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = 7'd8;
	localparam logic [NORM_W-1:0] NORM_DC_RST      = 15'd11585;
	localparam logic [NORM_W-1:0] NORM_AC_RST      = 15'd16384;

	// Request kinds on the input channel.
	localparam logic KIND_TABLE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// One product term handed to the multiply-accumulate pipeline.
	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last_term;
		logic [NORM_W-1:0] factor;
	} term_t;

	// Finished coefficient leaving the pipeline.
	typedef struct packed {
		logic              valid;
		logic [COEF_W-1:0] value;
	} mac_res_t;

	// Write and read requests for the sample buffer and cosine table.
	typedef struct packed {
		logic              smp_we;
		logic [SMP_AW-1:0] smp_waddr;
		logic [SMP_W-1:0]  smp_wdata;
		logic              cos_we;
		logic [TAB_AW-1:0] cos_waddr;
		logic [COS_W-1:0]  cos_wdata;
		logic              rd_en;
		logic [SMP_AW-1:0] smp_raddr;
		logic [TAB_AW-1:0] cos_raddr;
	} mem_req_t;

endpackage

FILE: sv/dctd_ifs.sv
// Handshake channel interfaces for input requests, results and configuration writes.
interface dctd_in_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic [dctd_pkg::TIDX_W-1:0]        table_index;
	logic signed [dctd_pkg::COS_W-1:0]  table_value;
	logic signed [dctd_pkg::SMP_W-1:0]  sample;

	modport source(output valid, kind, table_index, table_value, sample, input ready);
	modport sink(input valid, kind, table_index, table_value, sample, output ready);
endinterface

interface dctd_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [dctd_pkg::COEF_W-1:0] coefficient;
	logic                               last;

	modport source(output valid, coefficient, last, input ready);
	modport sink(input valid, coefficient, last, output ready);
endinterface

interface dctd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [dctd_pkg::CFG_IDX_W-1:0]    index;
	logic [dctd_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: sv/dctd_store.sv
// Sample buffer and cosine table memories with registered reads.
module dctd_store (
	input  logic                           clk,
	input  dctd_pkg::mem_req_t             req,
	output logic [dctd_pkg::SMP_W-1:0]     smp_rdata,
	output logic [dctd_pkg::COS_W-1:0]     cos_rdata
);

	logic [dctd_pkg::SMP_W-1:0] smp_mem [dctd_pkg::MAX_LEN];
	logic [dctd_pkg::COS_W-1:0] cos_mem [dctd_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.smp_we) begin
			smp_mem[req.smp_waddr] <= req.smp_wdata;
		end
		if (req.rd_en) begin
			smp_rdata <= smp_mem[req.smp_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.cos_we) begin
			cos_mem[req.cos_waddr] <= req.cos_wdata;
		end
		if (req.rd_en) begin
			cos_rdata <= cos_mem[req.cos_raddr];
		end
	end

endmodule

FILE: sv/dctd_mac.sv
// Pipelined multiply-accumulate with rounding and saturation to a 32-bit coefficient.
module dctd_mac (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dctd_pkg::term_t             term,
	input  logic [dctd_pkg::SMP_W-1:0]  smp_rdata,
	input  logic [dctd_pkg::COS_W-1:0]  cos_rdata,
	output dctd_pkg::mac_res_t          res
);

	localparam int ACC_W  = dctd_pkg::ACC_W;
	localparam int PB_W   = dctd_pkg::PB_W;
	localparam int COEF_W = dctd_pkg::COEF_W;
	localparam int RSH    = dctd_pkg::ROUND_SHIFT;

	localparam logic signed [ACC_W-1:0] ROUND_BIAS =
		{{(ACC_W-RSH){1'b0}}, 1'b1, {(RSH-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};

	// Control tags travel beside the data, one stage per register.
	logic v_s1, v_s2, v_s3, v_s4;
	logic first_s1, first_s2, first_s3;
	logic lt_s1, lt_s2, lt_s3;
	logic done_s4;
	logic res_valid_q;

	logic [dctd_pkg::NORM_W-1:0]        factor_s1;
	logic signed [dctd_pkg::PA_W-1:0]   pa_s2;
	logic signed [dctd_pkg::COS_W-1:0]  cos_s2;
	logic signed [PB_W-1:0]             pb_s3;
	logic signed [ACC_W-1:0]            acc_q;
	logic [COEF_W-1:0]                  res_value_q;

	logic signed [ACC_W-1:0] pb_ext;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-1:0] rnd_sh;
	logic [COEF_W-1:0]       sat_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			done_s4     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1        <= term.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			done_s4     <= v_s3 & lt_s3;
			res_valid_q <= v_s4 & done_s4;
		end
	end

	assign pb_ext = {{(ACC_W-PB_W){pb_s3[PB_W-1]}}, pb_s3};

	always_ff @(posedge clk) begin
		first_s1  <= term.first;
		lt_s1     <= term.last_term;
		factor_s1 <= term.factor;

		first_s2  <= first_s1;
		lt_s2     <= lt_s1;
		pa_s2     <= $signed({1'b0, factor_s1}) * $signed(smp_rdata);
		cos_s2    <= $signed(cos_rdata);

		first_s3  <= first_s2;
		lt_s3     <= lt_s2;
		pb_s3     <= pa_s2 * cos_s2;

		if (v_s3) begin
			acc_q <= first_s3 ? pb_ext : acc_q + pb_ext;
		end

		res_value_q <= sat_value;
	end

	// Round half up by adding half an LSB and flooring, then clamp to 32 bits.
	always_comb begin
		rnd    = acc_q + ROUND_BIAS;
		rnd_sh = rnd >>> RSH;
		if (rnd_sh > SAT_MAX) begin
			sat_value = SAT_MAX[COEF_W-1:0];
		end else if (rnd_sh < SAT_MIN) begin
			sat_value = SAT_MIN[COEF_W-1:0];
		end else begin
			sat_value = rnd_sh[COEF_W-1:0];
		end
	end

	assign res.valid = res_valid_q;
	assign res.value = res_value_q;

endmodule

FILE: sv/dct_ii_iii_direct.sv
// Top level of the direct orthonormal DCT-II / DCT-III block: control, configuration, output.
// The block collects N signed 16-bit samples (N = block_length, with zero acting as 1 and
// values above 64 acting as 64) and then emits N saturated 32-bit coefficients in index
// order, marking the final one with last. Table requests load the Q1.15 cosine table, which
// must hold cos(pi*i/(2N)) for every i below 4N before a block is computed; they take effect
// for all later blocks. The block takes a new input request every clock while it collects
// samples. After the Nth sample it stops taking requests and computes one coefficient at a
// time with a single shared multiply-accumulate fed from the sample and cosine memories:
// a coefficient costs a setup state, then N product terms issued one per clock, then a
// drain through the memory read, two multiplier stages, the accumulator and the rounding
// stage. The next coefficient starts only when the output register is free, so a stalled
// consumer holds the computation. Writing block_length discards a partly filled block.
// Configuration is taken at any time on a port that is always ready, but should only be
// written while no block is being computed.
module dct_ii_iii_direct (
	input  logic              clk,
	input  logic              arst_n,
	dctd_in_if.sink           din,
	dctd_out_if.source        dout,
	dctd_cfg_if.sink          cfg
);

	localparam int SMP_AW    = dctd_pkg::SMP_AW;
	localparam int TAB_AW    = dctd_pkg::TAB_AW;
	localparam int CNT_W     = dctd_pkg::CNT_W;
	localparam int IDX_SUM_W = dctd_pkg::IDX_SUM_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	// Configuration registers.
	logic [dctd_pkg::LEN_W-1:0]  block_length_q;
	logic                        inverse_mode_q;
	logic [dctd_pkg::NORM_W-1:0] norm_dc_q;
	logic [dctd_pkg::NORM_W-1:0] norm_ac_q;

	// Sequencer state and output register.
	state_t                      state_q;
	logic [CNT_W-1:0]            sample_count_q;
	logic [SMP_AW-1:0]           k_q;
	logic [SMP_AW-1:0]           n_q;
	logic [TAB_AW-1:0]           idx_q;
	logic [TAB_AW-1:0]           step_q;
	logic                        out_valid_q;
	logic [dctd_pkg::COEF_W-1:0] coefficient_q;
	logic                        last_q;

	logic                        cfg_wr;
	logic                        len_wr;
	logic                        in_acc;
	logic                        smp_acc;
	logic                        out_take;
	logic [CNT_W-1:0]            n_len;
	logic [SMP_AW-1:0]           last_idx;
	logic [IDX_SUM_W-1:0]        period;
	logic [CNT_W-1:0]            cnt_base;
	logic [CNT_W-1:0]            cnt_inc;
	logic [IDX_SUM_W-1:0]        idx_sum;
	logic [TAB_AW-1:0]           idx_next;
	logic [TAB_AW-1:0]           idx0;
	logic [TAB_AW-1:0]           step0;
	logic [SMP_AW-1:0]           norm_sel;

	dctd_pkg::mem_req_t          mem_req;
	dctd_pkg::term_t             term;
	dctd_pkg::mac_res_t          res;
	logic [dctd_pkg::SMP_W-1:0]  smp_rdata;
	logic [dctd_pkg::COS_W-1:0]  cos_rdata;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid & cfg.ready;
	assign len_wr    = cfg_wr & (cfg.index == dctd_pkg::REG_BLOCK_LENGTH);
	assign din.ready = (state_q == ST_IDLE);
	assign in_acc    = din.valid & din.ready;
	assign smp_acc   = in_acc & (din.kind == dctd_pkg::KIND_SAMPLE);
	assign out_take  = out_valid_q & dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= dctd_pkg::BLOCK_LENGTH_RST;
			inverse_mode_q <= 1'b0;
			norm_dc_q      <= dctd_pkg::NORM_DC_RST;
			norm_ac_q      <= dctd_pkg::NORM_AC_RST;
		end else if (cfg_wr) begin
			case (cfg.index)
				dctd_pkg::REG_BLOCK_LENGTH: block_length_q <= cfg.data[dctd_pkg::LEN_W-1:0];
				dctd_pkg::REG_INVERSE_MODE: inverse_mode_q <= cfg.data[0];
				dctd_pkg::REG_NORM_DC:      norm_dc_q      <= cfg.data[dctd_pkg::NORM_W-1:0];
				dctd_pkg::REG_NORM_AC:      norm_ac_q      <= cfg.data[dctd_pkg::NORM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The effective block length is the register clamped to 1..MAX_LEN.
	always_comb begin
		if (block_length_q == '0) begin
			n_len = CNT_W'(1);
		end else if (int'(block_length_q) > dctd_pkg::MAX_LEN) begin
			n_len = CNT_W'(dctd_pkg::MAX_LEN);
		end else begin
			n_len = CNT_W'(block_length_q);
		end
	end

	assign last_idx = SMP_AW'(n_len - CNT_W'(1));
	assign period   = IDX_SUM_W'({n_len, 2'b00});

	// A stale count left by a longer block length restarts at zero.
	assign cnt_base = (sample_count_q >= n_len) ? '0 : sample_count_q;
	assign cnt_inc  = cnt_base + CNT_W'(1);

	// Cosine index walks by a fixed step per term, wrapped into one period of 4N:
	// forward rows start at k with step 2k, inverse rows start at 0 with step 2k+1.
	assign idx_sum  = IDX_SUM_W'(idx_q) + IDX_SUM_W'(step_q);
	assign idx_next = (idx_sum >= period) ? TAB_AW'(idx_sum - period) : TAB_AW'(idx_sum);
	assign idx0     = inverse_mode_q ? '0 : TAB_AW'(k_q);
	assign step0    = TAB_AW'({k_q, inverse_mode_q});

	// The forward transform scales by the output index, the inverse by the input index.
	// Both sums are exact, so applying the factor per term gives the same total.
	assign norm_sel = inverse_mode_q ? n_q : k_q;

	always_comb begin
		term.valid     = (state_q == ST_ISSUE);
		term.first     = (n_q == '0);
		term.last_term = (n_q == last_idx);
		term.factor    = (norm_sel == '0) ? norm_dc_q : norm_ac_q;
	end

	always_comb begin
		mem_req.smp_we    = smp_acc;
		mem_req.smp_waddr = cnt_base[SMP_AW-1:0];
		mem_req.smp_wdata = din.sample;
		mem_req.cos_we    = in_acc & (din.kind == dctd_pkg::KIND_TABLE)
			& (int'(din.table_index) < dctd_pkg::TABLE_DEPTH);
		mem_req.cos_waddr = TAB_AW'(din.table_index);
		mem_req.cos_wdata = din.table_value;
		mem_req.rd_en     = (state_q == ST_ISSUE);
		mem_req.smp_raddr = n_q;
		mem_req.cos_raddr = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sample_count_q <= '0;
			k_q            <= '0;
			n_q            <= '0;
			idx_q          <= '0;
			step_q         <= '0;
			out_valid_q    <= 1'b0;
			coefficient_q  <= '0;
			last_q         <= 1'b0;
		end else begin
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						if (cnt_inc >= n_len) begin
							sample_count_q <= '0;
							k_q            <= '0;
							state_q        <= ST_PREP;
						end else begin
							sample_count_q <= len_wr ? '0 : cnt_inc;
						end
					end
				end
				ST_PREP: begin
					// Only one coefficient is in flight, so a free output register
					// here is still free when the coefficient lands.
					if (!out_valid_q || dout.ready) begin
						n_q     <= '0;
						idx_q   <= idx0;
						step_q  <= step0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					n_q   <= n_q + SMP_AW'(1);
					idx_q <= idx_next;
					if (n_q == last_idx) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (res.valid) begin
						out_valid_q   <= 1'b1;
						coefficient_q <= res.value;
						last_q        <= (k_q == last_idx);
						if (k_q == last_idx) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + SMP_AW'(1);
							state_q <= ST_PREP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// A new block length drops any partly collected block. A sample taken in
			// the same cycle already handles the clear above.
			if (len_wr && !smp_acc) begin
				sample_count_q <= '0;
			end
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.coefficient = coefficient_q;
	assign dout.last        = last_q;

	dctd_store u_store (
		.clk       (clk),
		.req       (mem_req),
		.smp_rdata (smp_rdata),
		.cos_rdata (cos_rdata)
	);

	dctd_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.term      (term),
		.smp_rdata (smp_rdata),
		.cos_rdata (cos_rdata),
		.res       (res)
	);

endmodule

FILE: test/dct_ii_iii_direct_tb.sv
// Self-checking testbench for the direct DCT-II / DCT-III block with its own transform predictor.
module dct_ii_iii_direct_tb;

	localparam int MAX_LEN     = dctd_pkg::MAX_LEN;
	localparam int TABLE_DEPTH = dctd_pkg::TABLE_DEPTH;
	localparam int LEN_W       = dctd_pkg::LEN_W;
	localparam int SMP_W       = dctd_pkg::SMP_W;
	localparam int COS_W       = dctd_pkg::COS_W;
	localparam int NORM_W      = dctd_pkg::NORM_W;
	localparam int TIDX_W      = dctd_pkg::TIDX_W;
	localparam int COEF_W      = dctd_pkg::COEF_W;
	localparam int CFG_IDX_W   = dctd_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = dctd_pkg::CFG_DATA_W;
	localparam int ROUND_SHIFT = dctd_pkg::ROUND_SHIFT;

	// Run length and pacing. The fixed limit covers every block with the receiver
	// stalling often, many times over.
	localparam int  CLK_HALF       = 5;
	localparam int  RESET_CYCLES   = 7;
	localparam int  SETTLE_CYCLES  = 16;
	localparam int  HOLD_CYCLES    = 400;
	localparam int  RANDOM_PHASES  = 8;
	localparam int  LONG_LEN       = 16;
	localparam int  TABLE_LOAD     = 4 * LONG_LEN;
	localparam longint RUN_LIMIT   = 5_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
	localparam longint COEF_MAX = 64'sd2147483647;
	localparam longint COEF_MIN = -COEF_MAX - 1;

	// One request on the input channel.
	typedef struct packed {
		logic                     kind;
		logic [TIDX_W-1:0]        tidx;
		logic signed [COS_W-1:0]  tval;
		logic signed [SMP_W-1:0]  smp;
	} dct_req_t;

	// One coefficient as it should leave the block.
	typedef struct {
		logic signed [COEF_W-1:0] value;
		logic                     last;
	} coef_t;

	typedef enum {STEP_REGISTER, STEP_REQUEST} step_kind_t;

	// A row of the directed plan: either a register write or a request, with an
	// optional hand-computed coefficient for single-sample blocks.
	typedef struct {
		step_kind_t                op;
		logic [CFG_IDX_W-1:0]      reg_idx;
		logic [CFG_DATA_W-1:0]     reg_data;
		dct_req_t                  req;
		bit                        typed;
		logic signed [COEF_W-1:0]  want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	dctd_in_if  din_ch ();
	dctd_out_if dout_ch ();
	dctd_cfg_if cfg_ch ();

	dct_ii_iii_direct u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: its own copy of the buffers and the registers.
	logic signed [SMP_W-1:0] pm_smp [MAX_LEN];
	logic signed [COS_W-1:0] pm_cos [TABLE_DEPTH];
	int unsigned             pm_fill;
	logic [LEN_W-1:0]        pm_len;
	logic                    pm_inv;
	logic [NORM_W-1:0]       pm_ndc;
	logic [NORM_W-1:0]       pm_nac;

	// Coefficients predicted but not yet seen on the output, oldest first.
	coef_t     pending_coefs [$];
	plan_row_t plan [$];

	// Pacing controls shared between the sender and the receiver.
	bit calm;
	bit hold_req;

	int req_count, smp_count, coef_count, block_count;
	int fwd_blocks, inv_blocks, longest, err_count;

	// Every mismatch goes through here: one line each, always counted.
	task automatic flag_error(input string msg);
		err_count++;
		$display("dct_ii_iii_direct_tb: mismatch at %0t: %s", $time, msg);
	endtask

	// Apply one accepted request to the predictor. A table request updates the cosine
	// copy; a sample fills the buffer, and the Nth one computes the whole block exactly
	// in 64-bit arithmetic, then rounds half up and saturates to 32 bits.
	function automatic void predict_request(input dct_req_t r);
		int unsigned n_eff, period, k, n, idx;
		longint      acc, nf;
		coef_t       c;
		if (pm_len == 0)
			n_eff = 1;
		else if (pm_len > MAX_LEN)
			n_eff = MAX_LEN;
		else
			n_eff = pm_len;
		if (r.kind == dctd_pkg::KIND_TABLE) begin
			pm_cos[r.tidx] = r.tval;
			return;
		end
		if (pm_fill >= n_eff)
			pm_fill = 0;
		pm_smp[pm_fill] = r.smp;
		pm_fill++;
		if (pm_fill < n_eff)
			return;
		pm_fill = 0;
		period = 4 * n_eff;
		block_count++;
		if (pm_inv)
			inv_blocks++;
		else
			fwd_blocks++;
		if (n_eff > longest)
			longest = n_eff;
		for (k = 0; k < n_eff; k++) begin
			acc = 0;
			if (!pm_inv) begin
				for (n = 0; n < n_eff; n++) begin
					idx = ((2 * n + 1) * k) % period;
					acc += longint'(pm_smp[n]) * longint'(pm_cos[idx]);
				end
				acc *= longint'((k == 0) ? pm_ndc : pm_nac);
			end else begin
				for (n = 0; n < n_eff; n++) begin
					idx = ((2 * k + 1) * n) % period;
					nf = longint'((n == 0) ? pm_ndc : pm_nac);
					acc += nf * longint'(pm_smp[n]) * longint'(pm_cos[idx]);
				end
			end
			// Arithmetic shift floors, so adding half first gives round half up.
			acc = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			if (acc > COEF_MAX)
				acc = COEF_MAX;
			if (acc < COEF_MIN)
				acc = COEF_MIN;
			c.value = acc[COEF_W-1:0];
			c.last = (k + 1 == n_eff);
			pending_coefs.push_back(c);
		end
	endfunction

	function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
	                                 input logic [CFG_DATA_W-1:0] data);
		plan_row_t s;
		s.op = STEP_REGISTER;
		s.reg_idx = idx;
		s.reg_data = data;
		s.req = '0;
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endfunction

	function automatic void plan_cos(input logic [TIDX_W-1:0] i, input logic signed [COS_W-1:0] v);
		plan_row_t s;
		s.op = STEP_REQUEST;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.req.kind = dctd_pkg::KIND_TABLE;
		s.req.tidx = i;
		s.req.tval = v;
		s.req.smp = '0;
		s.typed = 1'b0;
		s.want = '0;
		plan.push_back(s);
	endfunction

	function automatic void plan_sample(input logic signed [SMP_W-1:0] x, input bit typed = 1'b0,
	                                    input logic signed [COEF_W-1:0] want = '0);
		plan_row_t s;
		s.op = STEP_REQUEST;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.req.kind = dctd_pkg::KIND_SAMPLE;
		s.req.tidx = '0;
		s.req.tval = '0;
		s.req.smp = x;
		s.typed = typed;
		s.want = want;
		plan.push_back(s);
	endfunction

	// Normalization factors lean toward the two ends of their range.
	function automatic logic [NORM_W-1:0] pick_norm();
		case ($urandom_range(3, 0))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return NORM_W'($urandom);
			end
		endcase
	endfunction

	// Offer one request, with a random gap in front of it unless the phase is calm.
	// The request counts as taken at the rising edge where valid and ready are both high,
	// and only then does the predictor see it.
	task automatic send_request(input dct_req_t r);
		int gap;
		if (!calm && $urandom_range(99, 0) < 20) begin
			gap = $urandom_range(2, 1);
			@(negedge clk);
			din_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		din_ch.valid       <= 1'b1;
		din_ch.kind        <= r.kind;
		din_ch.table_index <= r.tidx;
		din_ch.table_value <= r.tval;
		din_ch.sample      <= r.smp;
		do
			@(posedge clk);
		while (din_ch.ready !== 1'b1);
		req_count++;
		if (r.kind == dctd_pkg::KIND_SAMPLE)
			smp_count++;
		predict_request(r);
	endtask

	// Stop offering requests, wait for every predicted coefficient, then let the block
	// settle so that it is back to collecting samples.
	task automatic settle_idle();
		@(negedge clk);
		din_ch.valid <= 1'b0;
		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only with the block idle. Writing block_length also
	// throws away a partly collected block, in the predictor as in the block.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle_idle();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		case (idx)
			dctd_pkg::REG_BLOCK_LENGTH: begin
				pm_len = data[LEN_W-1:0];
				pm_fill = 0;
			end
			dctd_pkg::REG_INVERSE_MODE: begin
				pm_inv = data[0];
			end
			dctd_pkg::REG_NORM_DC: begin
				pm_ndc = data[NORM_W-1:0];
			end
			dctd_pkg::REG_NORM_AC: begin
				pm_nac = data[NORM_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#RUN_LIMIT;
		$display("[dct_ii_iii_direct] ERROR");
		$finish;
	end

	// Receiver: ready changes at the falling edge, results are taken at the rising edge.
	// When asked for it, the receiver holds off for a long, counted stretch starting
	// with the first result it sees, so the block stops computing and then refuses input.
	initial begin
		int    hold_left;
		coef_t want;
		hold_left = 0;
		dout_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				dout_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				dout_ch.ready <= calm || ($urandom_range(99, 0) >= 20);
			end
			@(posedge clk);
			if (hold_req && dout_ch.valid === 1'b1 && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
				coef_count++;
				if (pending_coefs.size() == 0) begin
					flag_error($sformatf("coefficient %0d with none predicted", dout_ch.coefficient));
				end else begin
					want = pending_coefs.pop_front();
					if (dout_ch.coefficient !== want.value)
						flag_error($sformatf("coefficient %0d, predicted %0d",
							dout_ch.coefficient, want.value));
					if (dout_ch.last !== want.last)
						flag_error($sformatf("last %b, predicted %b", dout_ch.last, want.last));
				end
			end
		end
	end

	// Main stimulus: table load, directed plan, then random phases.
	initial begin
		int                 i, phase, j, n_items, v;
		logic [LEN_W-1:0]   len7;
		dct_req_t           r;
		coef_t              c;
		real                rv;

		// Every input of the block is known from time zero.
		arst_n             = 1'b0;
		din_ch.valid       = 1'b0;
		din_ch.kind        = dctd_pkg::KIND_SAMPLE;
		din_ch.table_index = '0;
		din_ch.table_value = '0;
		din_ch.sample      = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = '0;
		cfg_ch.data        = '0;

		// Predictor starts from the reset state of the block.
		foreach (pm_smp[k])
			pm_smp[k] = '0;
		foreach (pm_cos[k])
			pm_cos[k] = '0;
		pm_fill = 0;
		pm_len = dctd_pkg::BLOCK_LENGTH_RST;
		pm_inv = 1'b0;
		pm_ndc = dctd_pkg::NORM_DC_RST;
		pm_nac = dctd_pkg::NORM_AC_RST;
		calm = 1'b0;
		hold_req = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The low part of the cosine table is written first. It covers 4N entries for the
		// longest block this run uses, so no block ever reads an entry that was never
		// loaded. The values are a real Q1.15 cosine for N = 8, with 1.0 saturated to the
		// largest positive code.
		for (i = 0; i < TABLE_LOAD; i++) begin
			rv = $cos(3.14159265358979 * i / 16.0) * 32768.0;
			v = (rv >= 0.0) ? $rtoi(rv + 0.5) : $rtoi(rv - 0.5);
			if (v > 32767)
				v = 32767;
			r.kind = dctd_pkg::KIND_TABLE;
			r.tidx = TIDX_W'(i);
			r.tval = COS_W'(v);
			r.smp = SMP_W'($urandom);
			send_request(r);
		end

		// Directed plan. A two-sample block runs on the reset factors first.
		plan_reg(dctd_pkg::REG_BLOCK_LENGTH, 15'd2);
		plan_sample(16'sd12345);
		plan_sample(-16'sd321);
		// Single-sample blocks at the extremes: with C[0] = -1.0 and the largest factor,
		// the most negative sample gives 32767; a zero sample gives zero.
		plan_reg(dctd_pkg::REG_BLOCK_LENGTH, 15'd1);
		plan_reg(dctd_pkg::REG_NORM_DC, 15'h7FFF);
		plan_cos(8'd0, -16'sd32768);
		plan_sample(-16'sd32768, 1'b1, 32'sd32767);
		plan_sample(16'sd0, 1'b1, 32'sd0);
		plan_sample(16'sd32767);
		plan_cos(8'd0, 16'sd32767);
		plan_sample(16'sd32767);
		// The inverse of a single sample uses the same product.
		plan_reg(dctd_pkg::REG_INVERSE_MODE, 15'd1);
		plan_cos(8'd0, -16'sd32768);
		plan_sample(-16'sd32768, 1'b1, 32'sd32767);
		// A zero factor clears everything, also with a length of zero acting as one.
		plan_reg(dctd_pkg::REG_NORM_DC, 15'd0);
		plan_sample(-16'sd1, 1'b1, 32'sd0);
		plan_reg(dctd_pkg::REG_BLOCK_LENGTH, 15'd0);
		plan_sample(16'sd32767, 1'b1, 32'sd0);
		// A write to an index past the register list must change nothing.
		plan_reg(REG_UNMAPPED, 15'h7FFF);
		plan_reg(dctd_pkg::REG_NORM_DC, 15'd11585);
		plan_reg(dctd_pkg::REG_NORM_AC, 15'h7FFF);
		plan_reg(dctd_pkg::REG_INVERSE_MODE, 15'd0);
		plan_reg(dctd_pkg::REG_BLOCK_LENGTH, 15'd4);
		// Two samples of a block, then a length write discards them.
		plan_sample(16'sd100);
		plan_sample(-16'sd200);
		plan_reg(dctd_pkg::REG_BLOCK_LENGTH, 15'd4);
		// A table write in the middle of a block counts for that block.
		plan_sample(16'sd32767);
		plan_cos(8'd5, 16'sd12000);
		plan_sample(-16'sd32768);
		plan_sample(16'sd1);
		plan_sample(-16'sd1);
		// Inverse with a zero factor for every index but the first.
		plan_reg(dctd_pkg::REG_INVERSE_MODE, 15'd1);
		plan_reg(dctd_pkg::REG_NORM_AC, 15'd0);
		plan_sample(16'sd7);
		plan_sample(-16'sd32768);
		plan_sample(16'sd32767);
		plan_sample(16'sd2);

		foreach (plan[p]) begin
			if (plan[p].op == STEP_REGISTER) begin
				write_register(plan[p].reg_idx, plan[p].reg_data);
			end else begin
				// Fields the block must ignore carry random values.
				r = plan[p].req;
				if (r.kind == dctd_pkg::KIND_TABLE) begin
					r.smp = SMP_W'($urandom);
				end else begin
					r.tidx = TIDX_W'($urandom);
					r.tval = COS_W'($urandom);
				end
				send_request(r);
				if (plan[p].typed) begin
					void'(pending_coefs.pop_back());
					c.value = plan[p].want;
					c.last = 1'b1;
					pending_coefs.push_back(c);
				end
			end
		end

		// Random phases. Each one sets every register and then streams samples, with table
		// writes mixed in except in the hold-off phase. Most blocks are short; two phases run at
		// the longest length the loaded table covers, and one writes zero, which acts as one.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				1: begin
					len7 = LEN_W'(LONG_LEN);
				end
				3: begin
					len7 = 7'd0;
				end
				5: begin
					len7 = LEN_W'(LONG_LEN);
				end
				default: begin
					len7 = ($urandom_range(3, 0) == 0) ? LEN_W'($urandom_range(LONG_LEN, 9))
					                                   : LEN_W'($urandom_range(8, 1));
				end
			endcase
			// Bits above the register width ride along and must be dropped.
			write_register(dctd_pkg::REG_BLOCK_LENGTH, {8'($urandom), len7});
			write_register(dctd_pkg::REG_INVERSE_MODE, CFG_DATA_W'($urandom));
			write_register(dctd_pkg::REG_NORM_DC, pick_norm());
			write_register(dctd_pkg::REG_NORM_AC, pick_norm());
			if ($urandom_range(2, 0) == 0)
				write_register(CFG_IDX_W'($urandom_range(15, 4)), CFG_DATA_W'($urandom));

			// One phase runs with no idling on either side. The hold-off phase sends
			// samples only, so its block completes and the receiver then holds off while
			// a few more requests keep coming.
			calm = (phase == 2);
			if (phase == 1)
				hold_req = 1'b1;

			n_items = (phase == 1) ? LONG_LEN + 6 : ((len7 > 7'd8) ? int'(len7) + 6 : 12);
			for (j = 0; j < n_items; j++) begin
				r.kind = (phase != 1 && $urandom_range(99, 0) < 15) ? dctd_pkg::KIND_TABLE
				                                                    : dctd_pkg::KIND_SAMPLE;
				r.tidx = TIDX_W'($urandom);
				r.tval = COS_W'($urandom);
				case ($urandom_range(9, 0))
					0: begin
						r.smp = -16'sd32768;
					end
					1: begin
						r.smp = 16'sd32767;
					end
					2: begin
						r.smp = 16'sd0;
					end
					default: begin
						r.smp = SMP_W'($urandom);
					end
				endcase
				send_request(r);
			end
		end
		calm = 1'b0;

		settle_idle();

		$display("dct_ii_iii_direct_tb: %0d requests taken (%0d samples), %0d coefficients seen",
			req_count, smp_count, coef_count);
		$display("dct_ii_iii_direct_tb: %0d forward and %0d inverse blocks, longest %0d, %0d mismatches",
			fwd_blocks, inv_blocks, longest, err_count);
		if (err_count == 0)
			$display("[dct_ii_iii_direct] OK");
		else
			$display("[dct_ii_iii_direct] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
sv/dctd_pkg.sv
sv/dctd_ifs.sv
sv/dctd_store.sv
sv/dctd_mac.sv
sv/dct_ii_iii_direct.sv
test/dct_ii_iii_direct_tb.sv
